[hdl/pcfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcfr_pkg;

    localparam logic [3:0]  HDR_NIBBLE = 4'hA;
    localparam logic [31:0] ACK_WORD   = 32'h0600_00FA;
    localparam logic [31:0] NACK_WORD  = 32'h0200_000A;

    localparam logic [15:0] P1_RISE_RST = 16'h0060;
    localparam logic [15:0] P1_FALL_RST = 16'h1260;
    localparam logic [15:0] P2_RISE_RST = 16'h3F19;
    localparam logic [15:0] P2_FALL_RST = 16'h5119;

    localparam logic [1:0] LAST_BYTE_IDX = 2'd3;

    typedef enum logic [3:0] {
        MODE_ACK      = 4'd1,
        MODE_TRIGGER  = 4'd2,
        MODE_P1_END   = 4'd3,
        MODE_P2_END   = 4'd4,
        MODE_P2_START = 4'd5,
        MODE_P1_START = 4'd6
    } mode_t;

    typedef struct packed {
        logic [15:0] second_pulse_end;
        logic [15:0] second_pulse_start;
        logic [15:0] first_pulse_end;
        logic [15:0] first_pulse_start;
        logic        timing_updated;
        logic        trigger_start;
        logic        reply_is_ack;
        logic [31:0] reply_word;
    } reply_t;

endpackage

`default_nettype wire

[hdl/pcfr_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcfr_in_reg
    import pcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    output logic            item_valid,
    output logic [7:0]      item_byte,
    input  wire logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign s_tready = !valid_reg || item_take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

[hdl/pcfr_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcfr_core
    import pcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [7:0] item_byte,
    output logic            item_take,
    output logic            out_valid,
    input  wire logic       out_ready,
    output reply_t          out_reply
);

    logic        active_reg,  active_next;
    logic [1:0]  idx_reg,     idx_next;
    logic [23:0] acc_reg,     acc_next;
    logic [15:0] p1_rise_reg, p1_rise_next;
    logic [15:0] p1_fall_reg, p1_fall_next;
    logic [15:0] p2_rise_reg, p2_rise_next;
    logic [15:0] p2_fall_reg, p2_fall_next;
    logic        out_valid_reg, out_valid_next;
    reply_t      reply_reg,   reply_next;

    logic        finishing;
    logic        load_out;
    logic [31:0] word;
    logic [3:0]  mode;
    logic [15:0] value;
    logic        check_ok;
    logic        ack;
    logic        trig;
    logic        upd;

    assign finishing = active_reg && (idx_reg == LAST_BYTE_IDX);
    assign item_take = item_valid && !(finishing && out_valid_reg && !out_ready);
    assign load_out  = item_take && finishing;

    assign word     = {item_byte, acc_reg};
    assign mode     = word[7:4];
    assign value    = word[23:8];
    assign check_ok = ({3'b000, 5'($countones(word[23:0]))} == word[31:24]);

    always_comb
    begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        p1_rise_next = p1_rise_reg;
        p1_fall_next = p1_fall_reg;
        p2_rise_next = p2_rise_reg;
        p2_fall_next = p2_fall_reg;
        ack          = 1'b0;
        trig         = 1'b0;
        upd          = 1'b0;

        if (check_ok)
        begin
            ack = 1'b1;
            case (mode)
                MODE_ACK:      ;
                MODE_TRIGGER:  trig = 1'b1;
                MODE_P1_END:   upd  = 1'b1;
                MODE_P2_END:   upd  = 1'b1;
                MODE_P2_START: upd  = 1'b1;
                MODE_P1_START: upd  = 1'b1;
                default:       ack  = 1'b0;
            endcase
        end

        if (item_take)
        begin
            if (!active_reg)
            begin
                // open a frame on a header nibble, drop anything else
                if (item_byte[3:0] == HDR_NIBBLE)
                begin
                    active_next = 1'b1;
                    idx_next    = 2'd1;
                    acc_next    = {16'h0000, item_byte};
                end
            end
            else if (finishing)
            begin
                active_next = 1'b0;
                idx_next    = 2'd0;
                acc_next    = '0;
                if (check_ok)
                begin
                    case (mode)
                        MODE_P1_END:   p1_fall_next = value;
                        MODE_P2_END:   p2_fall_next = value;
                        MODE_P2_START: p2_rise_next = value;
                        MODE_P1_START: p1_rise_next = value;
                        default:       ;
                    endcase
                end
            end
            else
            begin
                acc_next[{idx_reg, 3'b000} +: 8] = item_byte;
                idx_next = idx_reg + 2'd1;
            end
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        reply_next                    = reply_reg;
        reply_next.reply_word         = ack ? ACK_WORD : NACK_WORD;
        reply_next.reply_is_ack       = ack;
        reply_next.trigger_start      = trig;
        reply_next.timing_updated     = upd;
        reply_next.first_pulse_start  = p1_rise_next;
        reply_next.first_pulse_end    = p1_fall_next;
        reply_next.second_pulse_start = p2_rise_next;
        reply_next.second_pulse_end   = p2_fall_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= 2'd0;
            acc_reg       <= '0;
            p1_rise_reg   <= P1_RISE_RST;
            p1_fall_reg   <= P1_FALL_RST;
            p2_rise_reg   <= P2_RISE_RST;
            p2_fall_reg   <= P2_FALL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            p1_rise_reg   <= p1_rise_next;
            p1_fall_reg   <= p1_fall_next;
            p2_rise_reg   <= p2_rise_next;
            p2_fall_reg   <= p2_fall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            reply_reg <= reply_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_reply = reply_reg;

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> active_reg)
        else $error("byte index set outside a frame");

    a_nack_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !reply_reg.reply_is_ack) |->
        (reply_reg.reply_word == NACK_WORD && !reply_reg.trigger_start
         && !reply_reg.timing_updated))
        else $error("nack reply carries ack content");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && reply_reg.trigger_start) |->
        (reply_reg.reply_is_ack && !reply_reg.timing_updated))
        else $error("trigger and timing update in one reply");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> ($stable(p1_rise_reg) && $stable(p1_fall_reg)
                       && $stable(p2_rise_reg) && $stable(p2_fall_reg)))
        else $error("pulse count changed without a reply");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("reply overwritten while stalled");

endmodule

`default_nettype wire

[hdl/pulse_command_frame_receiver.sv]
// Pulse command frame receiver.
// Slave channel s_*: one received serial byte per word in s_tdata[7:0].
// Idle bytes are dropped unless the low nibble is 0xA; that byte opens a
// four-byte frame (header, mode, 16-bit value, set-bit check).
// Master channel m_*: one reply word per completed frame, ACK or NACK, with
// the four pulse compare counts as they stand after the frame.
// The reply is registered: it shows on m_tvalid in the cycle after the last
// frame byte is taken, and a byte on s_* passes the input register, then the
// result register, before its reply is offered on m_*.
// Throughput: one byte per cycle unless a closing byte waits on a stalled reply;
// set by the single decode pass between the input and result registers.
// Reset: any open frame is closed, the compare counts return to their
// defaults and no reply is pending.
// Stall: a reply waits in the result register while m_tready is low; bytes
// within a frame keep flowing, and s_tready drops only when a closing byte
// needs the occupied result register.
`timescale 1ns / 1ps
`default_nettype none

module pulse_command_frame_receiver
    import pcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // reply_word, first_pulse_start, first_pulse_end,
                                        // second_pulse_start, second_pulse_end
    output logic [2:0]       m_tuser    // reply_is_ack, trigger_start, timing_updated
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_take;
    reply_t     reply;

    pcfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_take  (item_take)
    );

    pcfr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_take  (item_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_reply  (reply)
    );

    assign m_tdata = {reply.second_pulse_end, reply.second_pulse_start,
                      reply.first_pulse_end, reply.first_pulse_start,
                      reply.reply_word};
    assign m_tuser = {reply.timing_updated, reply.trigger_start, reply.reply_is_ack};

endmodule

`default_nettype wire

[tb/sv/pulse_command_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module pulse_command_frame_receiver_tb
    import pcfr_pkg::*;
();

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ACK,
        CHK_NACK
    } reply_chk_t;

    typedef struct {
        logic [31:0] word;
        int unsigned nbytes;
        reply_chk_t  chk;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;   // reply_word, first_pulse_start, first_pulse_end,
                            // second_pulse_start, second_pulse_end
    logic [2:0]  m_tuser;   // reply_is_ack, trigger_start, timing_updated

    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned errors = 0;

    reply_t      replies_due[$];
    stim_row_t   stim_rows[$];

    logic        frame_open;
    logic [1:0]  byte_pos;
    logic [31:0] frame_acc;
    logic [15:0] p1_rise;
    logic [15:0] p1_fall;
    logic [15:0] p2_rise;
    logic [15:0] p2_fall;

    pulse_command_frame_receiver u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned count_ones24(input logic [31:0] w);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 24; i++)
            n += w[i];
        return n;
    endfunction

    function automatic logic [31:0] build_frame(input logic [3:0] mode, input logic [15:0] value,
                                                input bit good_check);
        logic [31:0] w;
        logic [7:0]  chk;
        w = {8'h00, value, mode, HDR_NIBBLE};
        chk = 8'(count_ones24(w));
        if (!good_check)
            chk = chk + 8'($urandom_range(1, 255));
        w[31:24] = chk;
        return w;
    endfunction

    function automatic void clear_pulse_counts();
        frame_open = 1'b0;
        byte_pos = 2'd0;
        frame_acc = '0;
        p1_rise = P1_RISE_RST;
        p1_fall = P1_FALL_RST;
        p2_rise = P2_RISE_RST;
        p2_fall = P2_FALL_RST;
    endfunction

    function automatic bit take_byte(input logic [7:0] b, output reply_t r);
        logic [31:0] w;
        logic [15:0] value;
        logic        ack;
        logic        trig;
        logic        upd;
        r = '0;
        if (!frame_open)
        begin
            if (b[3:0] != HDR_NIBBLE)
                return 1'b0;
            frame_open = 1'b1;
            byte_pos = 2'd0;
            frame_acc = '0;
        end
        frame_acc[byte_pos*8 +: 8] = b;
        if (byte_pos != LAST_BYTE_IDX)
        begin
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end
        w = frame_acc;
        frame_open = 1'b0;
        byte_pos = 2'd0;
        frame_acc = '0;
        value = w[23:8];
        ack = 1'b0;
        trig = 1'b0;
        upd = 1'b0;
        if (count_ones24(w) == w[31:24])
        begin
            ack = 1'b1;
            case (w[7:4])
                MODE_ACK: ;
                MODE_TRIGGER: trig = 1'b1;
                MODE_P1_END:
                begin
                    p1_fall = value;
                    upd = 1'b1;
                end
                MODE_P2_END:
                begin
                    p2_fall = value;
                    upd = 1'b1;
                end
                MODE_P2_START:
                begin
                    p2_rise = value;
                    upd = 1'b1;
                end
                MODE_P1_START:
                begin
                    p1_rise = value;
                    upd = 1'b1;
                end
                default: ack = 1'b0;
            endcase
        end
        r.reply_word = ack ? ACK_WORD : NACK_WORD;
        r.reply_is_ack = ack;
        r.trigger_start = trig;
        r.timing_updated = upd;
        r.first_pulse_start = p1_rise;
        r.first_pulse_end = p1_fall;
        r.second_pulse_start = p2_rise;
        r.second_pulse_end = p2_fall;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input reply_chk_t chk);
        reply_t r;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (take_byte(b, r))
        begin
            if (chk == CHK_ACK)
            begin
                r.reply_word = ACK_WORD;
                r.reply_is_ack = 1'b1;
                r.trigger_start = 1'b0;
                r.timing_updated = 1'b0;
            end
            else if (chk == CHK_NACK)
            begin
                r.reply_word = NACK_WORD;
                r.reply_is_ack = 1'b0;
                r.trigger_start = 1'b0;
                r.timing_updated = 1'b0;
            end
            replies_due.push_back(r);
        end
    endtask

    task automatic send_word(input logic [31:0] w, input int unsigned nbytes,
                             input reply_chk_t chk);
        for (int i = 0; i < nbytes; i++)
            send_byte(w[i*8 +: 8], chk);
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic run_random(input int unsigned byte_target);
        int unsigned sent;
        int unsigned pick;
        int unsigned m;
        int unsigned n;
        sent = 0;
        while (sent < byte_target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_word(build_frame(4'($urandom_range(MODE_ACK, MODE_P1_START)),
                                      pick_value(), 1'b1), 4, CHK_MODEL);
                sent += 4;
            end
            else if (pick < 70)
            begin
                m = $urandom_range(7, 16);
                send_word(build_frame(4'(m), pick_value(), 1'b1), 4, CHK_MODEL);
                sent += 4;
            end
            else if (pick < 80)
            begin
                send_word(build_frame(4'($urandom), pick_value(), 1'b0), 4, CHK_MODEL);
                sent += 4;
            end
            else if (pick < 90)
            begin
                send_byte(8'($urandom), CHK_MODEL);
                sent += 1;
            end
            else
            begin
                n = $urandom_range(1, 3);
                send_word({$urandom} & 32'hFFFF_FFF0 | 32'(HDR_NIBBLE), n, CHK_MODEL);
                sent += n;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : reply_mon
        reply_t want;
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply expected none actual %h / %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("reply_word", want.reply_word, m_tdata[31:0]);
                check_field("first_pulse_start", 32'(want.first_pulse_start),
                            32'(m_tdata[47:32]));
                check_field("first_pulse_end", 32'(want.first_pulse_end),
                            32'(m_tdata[63:48]));
                check_field("second_pulse_start", 32'(want.second_pulse_start),
                            32'(m_tdata[79:64]));
                check_field("second_pulse_end", 32'(want.second_pulse_end),
                            32'(m_tdata[95:80]));
                check_field("reply_is_ack", 32'(want.reply_is_ack), 32'(m_tuser[0]));
                check_field("trigger_start", 32'(want.trigger_start), 32'(m_tuser[1]));
                check_field("timing_updated", 32'(want.timing_updated), 32'(m_tuser[2]));
            end
        end
    end

    initial
    begin
        clear_pulse_counts();
        stim_rows.push_back('{32'h0000_0000, 1, CHK_MODEL});
        stim_rows.push_back('{32'h0000_00FF, 1, CHK_MODEL});
        stim_rows.push_back('{build_frame(MODE_ACK, 16'h0000, 1'b1), 4, CHK_ACK});
        stim_rows.push_back('{build_frame(MODE_TRIGGER, 16'hFFFF, 1'b1), 4, CHK_MODEL});
        stim_rows.push_back('{build_frame(MODE_P1_END, 16'hFFFF, 1'b1), 4, CHK_MODEL});
        stim_rows.push_back('{build_frame(MODE_P2_END, 16'h0000, 1'b1), 4, CHK_MODEL});
        // header nibble in the value bytes must not restart the frame
        stim_rows.push_back('{build_frame(MODE_P2_START, 16'hAAAA, 1'b1), 4, CHK_MODEL});
        stim_rows.push_back('{build_frame(MODE_P1_START, 16'h1234, 1'b1), 4, CHK_MODEL});
        stim_rows.push_back('{build_frame(4'h0, 16'h5A5A, 1'b1), 4, CHK_NACK});
        stim_rows.push_back('{build_frame(4'hF, 16'hFFFF, 1'b1), 4, CHK_NACK});
        stim_rows.push_back('{build_frame(MODE_P1_END, 16'h0001, 1'b0), 4, CHK_NACK});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_word(stim_rows[i].word, stim_rows[i].nbytes, stim_rows[i].chk);
        s_tvalid <= 1'b0;
        wait (replies_due.size() == 0);
        @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 62;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct = 62;
                end
                default:
                begin
                    sender_idle_pct = 36;
                    sink_stall_pct = 36;
                end
            endcase
            run_random(180);
            // hold the sender until every reply is in
            s_tvalid <= 1'b0;
            wait (replies_due.size() == 0);
            @(posedge clk);
        end

        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hdl/pcfr_pkg.sv
hdl/pcfr_in_reg.sv
hdl/pcfr_core.sv
hdl/pulse_command_frame_receiver.sv
tb/sv/pulse_command_frame_receiver_tb.sv
